FILE: hdl/mwed_pkg.sv
package mwed_pkg;

    localparam int CHANNELS   = 5;
    localparam int RING_DEPTH = 80;
    localparam int WINDOW_LEN = 10;
    localparam int LATE_LIMIT = 4;

    localparam int SUM_W   = 32;
    localparam int SAMP_W  = 12;
    localparam int CNT7_W  = 7;
    localparam int RANGE_W = 12;
    localparam int TICK_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DET_CH_W   = 3;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W   = (RING_AW > 5) ? RING_AW : 5;

    // sum / WINDOW_LEN as (sum * DIV_RECIP) >> DIV_SHIFT; exact over 32 bits for a window of 10
    localparam int DIV_SHIFT = 35;
    localparam logic [2*SUM_W-1:0] DIV_RECIP =
        ((2*SUM_W)'(1) << DIV_SHIFT) / (2*SUM_W)'(WINDOW_LEN) + (2*SUM_W)'(1);

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_LEAST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET  = 3'd5;

    typedef logic [SAMP_W-1:0] t_samp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_SUM,
        S_DIV,
        S_STINIT,
        S_STEADY,
        S_STWAIT,
        S_PICK,
        S_SCAN,
        S_SCWAIT,
        S_EVAL,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clr_we;
        logic load;
        logic wr_new;
        logic sum;
        logic div_step;
        logic st_init;
        logic st_issue;
        logic sc_init;
        logic sc_issue;
        logic fire_set;
        logic next_ch;
        logic out_set;
    } t_cmd;

    typedef struct packed {
        logic ring_last;
        logic div_last;
        logic win_last;
        logic try_ch;
        logic ch_last;
        logic fire;
    } t_status;

    // exact |v - a| > r test, no signed overflow
    function automatic logic outside(input logic [SUM_W-1:0] v,
                                     input logic [SUM_W-1:0] a,
                                     input logic [RANGE_W-1:0] r);
        logic [SUM_W:0] vr;
        logic [SUM_W:0] ar;
        vr = {1'b0, v} + (SUM_W+1)'(r);
        ar = {1'b0, a} + (SUM_W+1)'(r);
        return ({1'b0, v} > ar) || (vr < {1'b0, a});
    endfunction

endpackage

FILE: hdl/multichannel_wave_event_detector.sv
// Multichannel wave event detector.
// Input channel: one beat per tick carries five 12-bit samples
// (i_sample_ch0..4), handshake i_in_valid / o_in_ready.
// Output channel: one beat per tick with the line level, a detect flag and
// the firing channel, handshake o_out_valid / i_out_ready.
// Config port: i_cfg_we, i_cfg_idx, i_cfg_data; the user writes it only
// while idle, and the block itself does not enforce this.
// Per input beat: write, sum, a reciprocal divide by the window length,
// steady reads over the window, a pick step per channel, and a scan of
// the whole ring for each channel that is scanned. Each ring RAM has a
// single read port. One tick is worked at a time; the next beat is taken
// in the cycle after the result is loaded.
// Reset: a clearing pass zeroes all 80 entries of the five ring RAMs, with
// o_in_ready low; config registers take their reset values at once.
// Stall: the result sits in an output register; a new tick is accepted
// while it waits, and the next result waits until that beat is taken.
module multichannel_wave_event_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mwed_pkg::SAMP_W-1:0]      i_sample_ch0,
    input  logic [mwed_pkg::SAMP_W-1:0]      i_sample_ch1,
    input  logic [mwed_pkg::SAMP_W-1:0]      i_sample_ch2,
    input  logic [mwed_pkg::SAMP_W-1:0]      i_sample_ch3,
    input  logic [mwed_pkg::SAMP_W-1:0]      i_sample_ch4,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_pulse_level,
    output logic                             o_detected,
    output logic [mwed_pkg::DET_CH_W-1:0]    o_detect_channel,
    input  logic                             i_cfg_we,
    input  logic [mwed_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mwed_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mwed_pkg::*;

    t_cmd    cmd;
    t_status st;
    t_samp   port_samp [5];
    t_samp   samp [CHANNELS];

    assign port_samp[0] = i_sample_ch0;
    assign port_samp[1] = i_sample_ch1;
    assign port_samp[2] = i_sample_ch2;
    assign port_samp[3] = i_sample_ch3;
    assign port_samp[4] = i_sample_ch4;

    // lanes beyond the five sample ports see zero
    for (genvar c = 0; c < CHANNELS; c++) begin : g_samp
        if (c < 5) begin : g_port
            assign samp[c] = port_samp[c];
        end else begin : g_zero
            assign samp[c] = '0;
        end
    end

    mwed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    mwed_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_samp          (samp),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_pulse_level   (o_pulse_level),
        .o_detected      (o_detected),
        .o_detect_channel(o_detect_channel)
    );
endmodule

FILE: hdl/mwed_ram.sv
module mwed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/mwed_ctrl.sv
module mwed_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mwed_pkg::t_status i_st,
    output mwed_pkg::t_cmd   o_cmd
);
    import mwed_pkg::*;

    t_state r_state, n_state;
    logic   r_ovld, n_ovld;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        n_ovld     = r_ovld && !i_out_ready;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (i_st.ring_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.wr_new = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_STINIT;
                end
            end
            S_STINIT: begin
                cmd.st_init = 1'b1;
                n_state     = S_STEADY;
            end
            S_STEADY: begin
                cmd.st_issue = 1'b1;
                if (i_st.win_last) begin
                    n_state = S_STWAIT;
                end
            end
            S_STWAIT: n_state = S_PICK;
            S_PICK: begin
                if (i_st.try_ch) begin
                    cmd.sc_init = 1'b1;
                    n_state     = S_SCAN;
                end else if (i_st.ch_last) begin
                    n_state = S_FINISH;
                end else begin
                    cmd.next_ch = 1'b1;
                end
            end
            S_SCAN: begin
                cmd.sc_issue = 1'b1;
                if (i_st.ring_last) begin
                    n_state = S_SCWAIT;
                end
            end
            S_SCWAIT: n_state = S_EVAL;
            S_EVAL: begin
                if (i_st.fire) begin
                    cmd.fire_set = 1'b1;
                    n_state      = S_FINISH;
                end else if (i_st.ch_last) begin
                    n_state = S_FINISH;
                end else begin
                    cmd.next_ch = 1'b1;
                    n_state     = S_PICK;
                end
            end
            S_FINISH: begin
                if (!r_ovld || i_out_ready) begin
                    cmd.out_set = 1'b1;
                    n_ovld      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_ovld;
endmodule

FILE: hdl/mwed_dp.sv
module mwed_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mwed_pkg::t_cmd                    i_cmd,
    output mwed_pkg::t_status                 o_st,
    input  mwed_pkg::t_samp                   i_samp [mwed_pkg::CHANNELS],
    input  logic                              i_cfg_we,
    input  logic [mwed_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mwed_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_pulse_level,
    output logic                              o_detected,
    output logic [mwed_pkg::DET_CH_W-1:0]     o_detect_channel
);
    import mwed_pkg::*;

    // config
    logic [CNT7_W-1:0]  r_least, r_most;
    logic [RANGE_W-1:0] r_wave, r_steady_rng;
    logic [TICK_W-1:0]  r_hold_ticks, r_quiet;

    // tick state
    logic [RING_AW-1:0] r_wi, n_wi;
    logic [TICK_W-1:0]  r_hold, n_hold;
    logic               r_line, n_line;
    logic [CH_W-1:0]    r_ch;
    logic               r_det;
    logic [CH_W-1:0]    r_which;

    // per lane
    t_samp              r_samp  [CHANNELS];
    logic [SUM_W-1:0]   r_sum   [CHANNELS];
    logic [SUM_W-1:0]   r_quo   [CHANNELS];
    logic [CHANNELS-1:0] r_stdy, r_sout;
    logic [SUM_W-1:0]   rdata   [CHANNELS];

    // sequencing
    logic [CNT_W-1:0]   r_cnt;
    logic [RING_AW-1:0] r_pos;
    logic               r_rd_vld, r_rd_scan, r_rd_start;
    logic [RING_AW-1:0] r_rd_addr;
    logic [RING_AW-1:0] r_rd_i;
    logic [CNT7_W-1:0]  r_up, r_dn, r_lup, r_ldn;

    // output payload
    logic               r_o_pulse, r_o_det;
    logic [DET_CH_W-1:0] r_o_ch;

    logic [RING_AW-1:0] old_idx, start_idx, pos_inc, pos_dec;
    logic [RING_AW-1:0] raddr, waddr;
    logic [SUM_W-1:0]   avg_ch, rd_ch;
    logic               up_fire, dn_fire;

    always_comb begin
        if (32'(r_wi) >= 32'(WINDOW_LEN)) begin
            old_idx = RING_AW'(32'(r_wi) - WINDOW_LEN);
        end else begin
            old_idx = RING_AW'(32'(r_wi) + RING_DEPTH - WINDOW_LEN);
        end
        start_idx = (old_idx == '0) ? RING_AW'(RING_DEPTH - 1) : old_idx;
        pos_inc   = (32'(r_pos) == RING_DEPTH - 1) ? '0 : r_pos + 1'b1;
        pos_dec   = (r_pos == '0) ? RING_AW'(RING_DEPTH - 1) : r_pos - 1'b1;
        n_wi      = (32'(r_wi) == RING_DEPTH - 1) ? '0 : r_wi + 1'b1;
    end

    // hold counter and line level, updated as a tick is taken
    always_comb begin
        n_hold = r_hold;
        n_line = r_line;
        if (r_hold != '0) begin
            n_hold = r_hold - 1'b1;
            if (n_hold > r_quiet) begin
                n_line = 1'b1;
            end else if (n_hold == r_quiet) begin
                n_line = 1'b0;
            end
        end
    end

    assign avg_ch = r_quo[r_ch];
    assign rd_ch  = rdata[r_ch];

    // read address shared by all lanes
    always_comb begin
        if (i_cmd.wr_new) begin
            raddr = old_idx;
        end else if (i_cmd.st_issue && 32'(r_cnt) == WINDOW_LEN) begin
            raddr = start_idx;
        end else begin
            raddr = r_pos;
        end
        waddr = i_cmd.clr_we ? RING_AW'(r_cnt) : (i_cmd.wr_new ? r_wi : r_rd_addr);
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        logic               we;
        logic [SUM_W-1:0]   wdata;
        logic [SUM_W-1:0]   new_sum;
        logic [2*SUM_W-1:0] prod;

        always_comb begin
            we    = i_cmd.clr_we || i_cmd.wr_new ||
                    (r_rd_vld && r_rd_scan && r_ch == CH_W'(c));
            wdata = i_cmd.clr_we ? '0 :
                    (i_cmd.wr_new ? SUM_W'(r_samp[c]) : r_quo[c]);
            new_sum = r_sum[c] + SUM_W'(r_samp[c]) - rdata[c];
            prod    = (2*SUM_W)'(r_quo[c]) * DIV_RECIP;
        end

        mwed_ram #(.WIDTH(SUM_W), .DEPTH(RING_DEPTH)) u_ring (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(waddr),
            .i_wdata(wdata),
            .i_raddr(raddr),
            .o_rdata(rdata[c])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[c] <= '0;
            end else if (i_cmd.sum) begin
                r_sum[c] <= new_sum;
            end
            if (i_cmd.load) begin
                r_samp[c] <= i_samp[c];
            end
            // sum is parked in r_quo, then replaced by its average in one step
            if (i_cmd.sum) begin
                r_quo[c] <= new_sum;
            end else if (i_cmd.div_step) begin
                r_quo[c] <= SUM_W'(prod[2*SUM_W-1:DIV_SHIFT]);
            end
            if (i_cmd.st_init) begin
                r_stdy[c] <= 1'b1;
                r_sout[c] <= 1'b0;
            end else if (r_rd_vld && !r_rd_scan) begin
                if (r_rd_start) begin
                    r_sout[c] <= outside(rdata[c], r_quo[c], r_wave);
                end else if (outside(rdata[c], r_quo[c], r_steady_rng)) begin
                    r_stdy[c] <= 1'b0;
                end
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_least      <= CNT7_W'(2);
            r_most       <= CNT7_W'(20);
            r_wave       <= RANGE_W'(30);
            r_steady_rng <= RANGE_W'(20);
            r_hold_ticks <= TICK_W'(90);
            r_quiet      <= TICK_W'(80);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEAST:  r_least      <= i_cfg_data[CNT7_W-1:0];
                CFG_MOST:   r_most       <= i_cfg_data[CNT7_W-1:0];
                CFG_WAVE:   r_wave       <= i_cfg_data[RANGE_W-1:0];
                CFG_STEADY: r_steady_rng <= i_cfg_data[RANGE_W-1:0];
                CFG_HOLD:   r_hold_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_QUIET:  r_quiet      <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi     <= '0;
            r_hold   <= '0;
            r_line   <= 1'b0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_ch     <= '0;
            r_det    <= 1'b0;
            r_which  <= '0;
        end else begin
            r_rd_vld <= i_cmd.st_issue || i_cmd.sc_issue;
            if (i_cmd.load) begin
                r_wi    <= n_wi;
                r_hold  <= n_hold;
                r_line  <= n_line;
                r_ch    <= '0;
                r_det   <= 1'b0;
                r_which <= '0;
            end
            if (i_cmd.next_ch) begin
                r_ch <= r_ch + 1'b1;
            end
            if (i_cmd.fire_set) begin
                r_hold  <= r_hold_ticks;
                r_det   <= 1'b1;
                r_which <= r_ch;
            end
            if (i_cmd.sum || i_cmd.st_init || i_cmd.sc_init) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_we) begin
                r_cnt <= (32'(r_cnt) == RING_DEPTH - 1) ? '0 : r_cnt + 1'b1;
            end else if (i_cmd.div_step || i_cmd.st_issue || i_cmd.sc_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // read pointer, read tags, scan counts and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.st_init) begin
            r_pos <= (32'(old_idx) == RING_DEPTH - 1) ? '0 : old_idx + 1'b1;
        end else if (i_cmd.sc_init) begin
            r_pos <= start_idx;
        end else if (i_cmd.st_issue) begin
            r_pos <= pos_inc;
        end else if (i_cmd.sc_issue) begin
            r_pos <= pos_dec;
        end
        r_rd_scan  <= i_cmd.sc_issue;
        r_rd_start <= i_cmd.st_issue && 32'(r_cnt) == WINDOW_LEN;
        r_rd_addr  <= r_pos;
        r_rd_i     <= RING_AW'(r_cnt);
        if (i_cmd.sc_init) begin
            r_up  <= '0;
            r_dn  <= '0;
            r_lup <= '0;
            r_ldn <= '0;
        end else if (r_rd_vld && r_rd_scan) begin
            if ({1'b0, rd_ch} > {1'b0, avg_ch} + (SUM_W+1)'(r_wave)) begin
                if (32'(r_rd_i) > 32'(r_most)) r_lup <= r_lup + 1'b1;
                else                           r_up  <= r_up + 1'b1;
            end else if ({1'b0, rd_ch} + (SUM_W+1)'(r_wave) < {1'b0, avg_ch}) begin
                if (32'(r_rd_i) > 32'(r_most)) r_ldn <= r_ldn + 1'b1;
                else                           r_dn  <= r_dn + 1'b1;
            end
        end
        if (i_cmd.out_set) begin
            r_o_pulse <= r_line;
            r_o_det   <= r_det;
            r_o_ch    <= DET_CH_W'(r_which);
        end
    end

    assign up_fire = (r_up > r_least) && (r_up < r_most) && (32'(r_lup) < LATE_LIMIT);
    assign dn_fire = (r_dn > r_least) && (r_dn < r_most) && (32'(r_ldn) < LATE_LIMIT);

    assign o_st.ring_last = (32'(r_cnt) == RING_DEPTH - 1);
    assign o_st.div_last  = 1'b1;   // divide finishes in S_DIV, with no iteration
    assign o_st.win_last  = (32'(r_cnt) == WINDOW_LEN);
    assign o_st.try_ch    = (r_hold == '0) && r_stdy[r_ch] && r_sout[r_ch];
    assign o_st.ch_last   = (32'(r_ch) == CHANNELS - 1);
    assign o_st.fire      = up_fire || dn_fire;

    assign o_pulse_level    = r_o_pulse;
    assign o_detected       = r_o_det;
    assign o_detect_channel = r_o_ch;
endmodule
